// ----- hdl/utf8d_pkg.sv -----
package utf8d_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] REPL_RESET   = 21'h00FFFD;
    localparam logic [CP_W-1:0] MIN_TWO      = 21'h000080;
    localparam logic [CP_W-1:0] MIN_THREE    = 21'h000800;
    localparam logic [CP_W-1:0] MIN_FOUR     = 21'h010000;
    localparam logic [CP_W-1:0] SURR_LO      = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI      = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;

    localparam logic [1:0] SEQ_NONE  = 2'd0;
    localparam logic [1:0] SEQ_TWO   = 2'd1;
    localparam logic [1:0] SEQ_THREE = 2'd2;
    localparam logic [1:0] SEQ_FOUR  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_marker;
    } in_item_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            is_error;
        logic            last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } step_res_t;

    typedef struct packed {
        logic            emit;
        logic            err;
        logic [CP_W-1:0] cp;
        logic [1:0]      seq_len;
        logic [CP_W-1:0] partial;
    } lead_t;

    function automatic lead_t decode_lead(input logic [7:0] b, input logic [CP_W-1:0] repl);
        lead_t r;
        r.emit    = 1'b0;
        r.err     = 1'b0;
        r.cp      = '0;
        r.seq_len = SEQ_NONE;
        r.partial = '0;
        if (b[7] == 1'b0)
        begin
            r.emit = 1'b1;
            r.cp   = {13'd0, b};
        end
        else if (b[7:5] == 3'b110)
        begin
            r.seq_len = SEQ_TWO;
            r.partial = {16'd0, b[4:0]};
        end
        else if (b[7:4] == 4'b1110)
        begin
            r.seq_len = SEQ_THREE;
            r.partial = {17'd0, b[3:0]};
        end
        else if (b[7:3] == 5'b11110)
        begin
            r.seq_len = SEQ_FOUR;
            r.partial = {18'd0, b[2:0]};
        end
        else
        begin
            r.emit = 1'b1;
            r.err  = 1'b1;
            r.cp   = repl;
        end
        return r;
    endfunction

endpackage

// ----- hdl/utf8d_step.sv -----
module utf8d_step
    import utf8d_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  in_item_t        item,
    input  logic [CP_W-1:0] repl,
    output step_res_t       res
);

    logic [1:0]      bytes_left_reg, bytes_left_next;
    logic [1:0]      seq_length_reg, seq_length_next;
    logic [CP_W-1:0] partial_reg, partial_next;

    lead_t           lead;
    logic [CP_W-1:0] value;
    logic            bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= SEQ_NONE;
            seq_length_reg <= SEQ_NONE;
            partial_reg    <= '0;
        end
        else if (accept)
        begin
            bytes_left_reg <= bytes_left_next;
            seq_length_reg <= seq_length_next;
            partial_reg    <= partial_next;
        end
    end

    always_comb
    begin
        lead  = decode_lead(item.data_byte, repl);
        value = {partial_reg[CP_W-7:0], item.data_byte[5:0]};
        bad   = 1'b0;
        unique case (seq_length_reg)
            SEQ_TWO:   bad = value < MIN_TWO;
            SEQ_THREE: bad = value < MIN_THREE;
            SEQ_FOUR:  bad = value < MIN_FOUR;
            default:   bad = 1'b0;
        endcase
        if ((value >= SURR_LO && value <= SURR_HI) || value > CP_MAX)
            bad = 1'b1;

        bytes_left_next = SEQ_NONE;
        seq_length_next = SEQ_NONE;
        partial_next    = '0;
        res.count       = 2'd0;
        res.first       = '{code_point: repl, is_error: 1'b1, last_of_run: 1'b1};
        res.second      = '{code_point: lead.cp, is_error: lead.err, last_of_run: 1'b1};

        if (item.end_marker)
        begin
            if (bytes_left_reg != SEQ_NONE)
                res.count = 2'd1;
        end
        else if (bytes_left_reg == SEQ_NONE)
        begin
            if (lead.emit)
            begin
                res.count = 2'd1;
                res.first = '{code_point: lead.cp, is_error: lead.err, last_of_run: 1'b1};
            end
            else
            begin
                bytes_left_next = lead.seq_len;
                seq_length_next = lead.seq_len;
                partial_next    = lead.partial;
            end
        end
        else if (item.data_byte[7:6] == 2'b10)
        begin
            if (bytes_left_reg != 2'd1)
            begin
                bytes_left_next = bytes_left_reg - 2'd1;
                seq_length_next = seq_length_reg;
                partial_next    = value;
            end
            else
            begin
                res.count = 2'd1;
                if (!bad)
                    res.first = '{code_point: value, is_error: 1'b0, last_of_run: 1'b1};
            end
        end
        else
        begin
            res.count = 2'd1;
            if (lead.emit)
            begin
                res.count             = 2'd2;
                res.first.last_of_run = 1'b0;
            end
            else
            begin
                bytes_left_next = lead.seq_len;
                seq_length_next = lead.seq_len;
                partial_next    = lead.partial;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        bytes_left_reg <= seq_length_reg)
        else $error("pending byte count exceeds sequence length");

    assert property (@(posedge clk) disable iff (!rst_n)
        res.count == 2'd2 |-> bytes_left_reg != SEQ_NONE && !item.end_marker)
        else $error("two results without an interrupted sequence");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.end_marker |=> bytes_left_reg == SEQ_NONE)
        else $error("end of input left a sequence pending");

endmodule

// ----- hdl/utf8d_outq.sv -----
module utf8d_outq
    import utf8d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  step_res_t res,
    output logic      full,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    out_item_t  mem [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] n_push;
    logic       pop;

    assign n_push    = push ? res.count : 2'd0;
    assign out_valid = count_reg != 3'd0;
    assign pop       = out_valid && !out_stall;
    assign full      = count_reg > 3'd2;
    assign out_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + n_push;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, n_push} - {2'b00, pop};
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            mem[wr_ptr_reg] <= res.first;
        if (n_push == 2'd2)
            mem[wr_ptr_reg + 2'd1] <= res.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        n_push != 2'd0 |-> count_reg <= 3'd2)
        else $error("write into a queue without room for two results");

    assert property (@(posedge clk) disable iff (!rst_n)
        wr_ptr_reg - rd_ptr_reg == count_reg[1:0])
        else $error("queue pointers disagree with fill count");

endmodule

// ----- hdl/utf8_validating_decoder_top.sv -----
// UTF-8 validating decoder: one byte (or an end-of-input mark) per transfer on the byte
// channel, decoded code points on the result channel. A byte is taken every cycle
// while byte_stall is low; each transfer updates the sequence state in one pass and
// writes zero, one or two results into a four-entry result queue, and byte_stall
// rises while that queue holds more than two results. With the result side never
// stalling, single-result traffic runs at one byte per cycle, and the two results of
// an interrupted sequence leave the queue in turn. Results are registered in the queue.
// Invalid, overlong, surrogate, out-of-range or truncated sequences give the
// replacement value, written through cfg_write_en/cfg_write_data (0xFFFD after reset).
module utf8_validating_decoder_top
    import utf8d_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    output logic            byte_stall,
    input  in_item_t        byte_item,
    output logic            cp_valid,
    input  logic            cp_stall,
    output out_item_t       cp_item,
    input  logic            cfg_write_en,
    input  logic [CP_W-1:0] cfg_write_data
);

    logic [CP_W-1:0] repl_reg;
    logic            accept;
    logic            full;
    step_res_t       res;

    assign byte_stall = full;
    assign accept     = byte_valid && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            repl_reg <= REPL_RESET;
        else if (cfg_write_en)
            repl_reg <= cfg_write_data;
    end

    utf8d_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (byte_item),
        .repl   (repl_reg),
        .res    (res)
    );

    utf8d_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .res       (res),
        .full      (full),
        .out_valid (cp_valid),
        .out_stall (cp_stall),
        .out_item  (cp_item)
    );

endmodule
